[rtl/lrn_pkg.sv]
package lrn_pkg;

  localparam int MAX_ORDER_DEF = 1024;
  localparam int VAL_W         = 27;
  localparam int ORDER_W       = 11;
  localparam int POS_W         = 11;
  localparam int CMD_W         = 2;
  localparam int NUM_W         = 60;

  localparam logic [VAL_W-1:0] PRIME = 27'd104857601;
  // floor(2^56 / PRIME), used for the reciprocal estimate of the quotient
  localparam logic [29:0] BARRETT = 30'(64'd72057594037927936 / 64'd104857601);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_TERM = 2'd0,
    CMD_LOAD_COEF = 2'd1,
    CMD_RUN       = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  // negate modulo the prime
  function automatic logic [VAL_W-1:0] mod_neg(input logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] r;
    begin
      r = (x == '0) ? '0 : PRIME - x;
      return r;
    end
  endfunction

  // add two reduced values modulo the prime
  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
      return s[VAL_W-1:0];
    end
  endfunction

  // reduce a value below twice the prime
  function automatic logic [VAL_W-1:0] red_once(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    begin
      r = (v >= PRIME) ? v - PRIME : v;
      return r;
    end
  endfunction

  // reduce a value below three times the prime
  function automatic logic [VAL_W-1:0] red_twice(input logic [VAL_W+1:0] v);
    logic [VAL_W+1:0] r;
    begin
      r = v;
      if (r >= {PRIME, 1'b0} + 29'd0) r = r - {1'b0, PRIME, 1'b0};
      else if (r >= {2'b00, PRIME}) r = r - {2'b00, PRIME};
      return r[VAL_W-1:0];
    end
  endfunction

endpackage

[rtl/lrn_ram.sv]
module lrn_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/linear_recurrence_nth_term_mod.sv]
// N-th term of an order-k linear recurrence modulo 104857601.
// Configuration: cfg_we/cfg_data write the order k (0 acts as 1, values
// above MAX_ORDER act as MAX_ORDER); write it only while the block is idle.
// Input channel (in_valid/in_ready): load-term and load-coefficient items
// are taken one per cycle and give no result. A run item starts the
// halving computation; in_ready stays low until the run has finished.
// Output channel (out_valid/out_ready): one term per run, held in an output
// register until taken. A stalled receiver does not block loads; a following
// run waits at its end until the previous term has been taken.
// Run: each halving step extends the terms to 2k (k products per new
// term), then runs the squaring pass and the copy, parity, halve and
// test passes; about log2(n/k)+1 steps run, then the term is read out.
// The products come from the single multiply-accumulate pipeline (one
// product a cycle while a pass issues, drained after each result) fed
// from the term and denominator memories.
// Reset clears the control state and sets k to 1; the memories hold no
// reset value, loaded terms and coefficients must be reloaded for each run.
module linear_recurrence_nth_term_mod #(
  parameter int MAX_ORDER = lrn_pkg::MAX_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lrn_pkg::ORDER_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lrn_pkg::CMD_W-1:0]    in_command,
  input  logic [lrn_pkg::POS_W-1:0]    in_position,
  input  logic [lrn_pkg::VAL_W-1:0]    in_value,
  input  logic [lrn_pkg::NUM_W-1:0]    in_term_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lrn_pkg::VAL_W-1:0]    out_term
);
  import lrn_pkg::*;

  localparam int TAW = $clog2(2 * MAX_ORDER);
  localparam int DAW = $clog2(MAX_ORDER + 1);
  localparam int CW  = $clog2(2 * MAX_ORDER + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TEST, S_EXT_ISSUE, S_EXT_WAIT, S_SQ_ISSUE, S_SQ_WAIT,
    S_COPY, S_COPY_END, S_PAR, S_PAR_END, S_HALVE, S_OUT_RD, S_OUT_DATA
  } state_t;

  state_t               state_r;
  logic [ORDER_W-1:0]   order_r;
  logic [NUM_W-1:0]     n_r;
  logic [CW-1:0]        o_r, j_r, hi_r, xa_r;
  logic                 first_r, xv_r;
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_term_r;

  logic [CW-1:0]        k, k2;
  logic [CW:0]          top_c, top_n;
  logic [CW-1:0]        lo_n, hi_n;
  logic                 accept;

  // memory ports
  logic             t_we, d_we, h_we;
  logic [TAW-1:0]   t_waddr, t_raddr;
  logic [DAW-1:0]   d_waddr, da_raddr, db_raddr, h_waddr, h_raddr;
  logic [VAL_W-1:0] t_wdata, d_wdata, h_wdata;
  logic [VAL_W-1:0] term_rd, dena_rd, denb_rd, half_rd;

  // multiply-accumulate pipeline
  logic             iss_v, iss_last, iss_ext, iss_za, iss_zb, iss_odd;
  logic             v1_r, f1_r, l1_r, ext1_r, za1_r, zb1_r, odd1_r;
  logic             v2_r, f2_r, l2_r, v3_r, f3_r, l3_r, v4_r, f4_r, l4_r;
  logic [VAL_W-1:0] a1, bb1, b1;
  logic [2*VAL_W-1:0] p2_r;
  logic [57:0]      t3_r;
  logic [VAL_W+1:0] p3_r, r4_r;
  logic [54:0]      qp;
  logic [VAL_W-1:0] acc_r, acc_base;
  logic             done_r;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_term  = out_term_r;

  // effective order and loop bounds
  always_comb begin
    if (order_r == '0) k = CW'(1);
    else if (32'(order_r) > MAX_ORDER) k = CW'(MAX_ORDER);
    else k = CW'(order_r);
    k2    = k << 1;
    top_c = {o_r, 1'b0};
    top_n = ({1'b0, o_r} + 1'b1) << 1;
    lo_n  = (top_n > {1'b0, k}) ? CW'(top_n - {1'b0, k}) : '0;
    hi_n  = (top_n < {1'b0, k}) ? CW'(top_n) : k;
  end

  // issue one product per cycle in the extension and squaring passes
  always_comb begin
    iss_v    = 1'b0;
    iss_last = 1'b0;
    iss_ext  = 1'b0;
    iss_za   = 1'b0;
    iss_zb   = 1'b0;
    iss_odd  = 1'b0;
    case (state_r)
      S_EXT_ISSUE: begin
        iss_v    = 1'b1;
        iss_ext  = 1'b1;
        iss_last = (j_r == k);
      end
      S_SQ_ISSUE: begin
        iss_v    = 1'b1;
        iss_last = (j_r == hi_r);
        iss_za   = (j_r == '0);
        iss_zb   = (top_c == {1'b0, j_r});
        iss_odd  = j_r[0];
      end
      default: ;
    endcase
  end

  // memory addressing and write selection
  always_comb begin
    t_we     = 1'b0;
    t_waddr  = TAW'(o_r);
    t_wdata  = acc_r;
    d_we     = 1'b0;
    d_waddr  = DAW'(xa_r);
    d_wdata  = half_rd;
    h_we     = 1'b0;
    h_waddr  = DAW'(o_r);
    h_wdata  = acc_r;
    h_raddr  = DAW'(o_r);
    da_raddr = DAW'(j_r);
    db_raddr = DAW'(top_c - {1'b0, j_r});
    case (state_r)
      S_EXT_ISSUE: t_raddr = TAW'(o_r - j_r);
      S_PAR:       t_raddr = TAW'({o_r, n_r[0]});
      default:     t_raddr = TAW'(n_r);
    endcase
    case (state_r)
      S_IDLE: begin
        if (accept && in_command == CMD_LOAD_TERM && 32'(in_position) < MAX_ORDER) begin
          t_we    = 1'b1;
          t_waddr = TAW'(in_position);
          t_wdata = red_once(in_value);
        end
        if (accept && in_command == CMD_LOAD_COEF && in_position != '0 &&
            32'(in_position) <= MAX_ORDER) begin
          d_we    = 1'b1;
          d_waddr = DAW'(in_position);
          d_wdata = mod_neg(red_once(in_value));
        end
      end
      S_EXT_WAIT: t_we = done_r;
      S_SQ_WAIT:  h_we = done_r;
      S_COPY, S_COPY_END: d_we = xv_r;
      S_PAR, S_PAR_END: begin
        t_we    = xv_r;
        t_waddr = TAW'(xa_r);
        t_wdata = term_rd;
      end
      default: ;
    endcase
  end

  lrn_ram #(.WIDTH(VAL_W), .DEPTH(2 * MAX_ORDER)) u_term_ram (
    .clk(clk), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
    .rd_addr(t_raddr), .rd_data(term_rd)
  );

  // two copies of the denominator for the two squaring operands
  lrn_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ORDER + 1)) u_den_a_ram (
    .clk(clk), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
    .rd_addr(da_raddr), .rd_data(dena_rd)
  );

  lrn_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ORDER + 1)) u_den_b_ram (
    .clk(clk), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
    .rd_addr(db_raddr), .rd_data(denb_rd)
  );

  lrn_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ORDER + 1)) u_half_ram (
    .clk(clk), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
    .rd_addr(h_raddr), .rd_data(half_rd)
  );

  // select operands; the constant coefficient always reads as one
  always_comb begin
    a1  = ext1_r ? mod_neg(dena_rd) : (za1_r ? VAL_W'(1) : dena_rd);
    bb1 = zb1_r ? VAL_W'(1) : denb_rd;
    b1  = ext1_r ? term_rd : (odd1_r ? mod_neg(bb1) : bb1);
    qp  = 55'(t3_r[57:30]) * 55'(PRIME);
    acc_base = f4_r ? '0 : acc_r;
  end

  // multiply, estimate quotient, subtract, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= iss_v;
      f1_r   <= first_r;
      l1_r   <= iss_last;
      ext1_r <= iss_ext;
      za1_r  <= iss_za;
      zb1_r  <= iss_zb;
      odd1_r <= iss_odd;
      v2_r   <= v1_r;
      f2_r   <= f1_r;
      l2_r   <= l1_r;
      p2_r   <= (2*VAL_W)'(a1) * (2*VAL_W)'(b1);
      v3_r   <= v2_r;
      f3_r   <= f2_r;
      l3_r   <= l2_r;
      t3_r   <= 58'(p2_r[2*VAL_W-1:26]) * 58'(BARRETT);
      p3_r   <= p2_r[VAL_W+1:0];
      v4_r   <= v3_r;
      f4_r   <= f3_r;
      l4_r   <= l3_r;
      r4_r   <= p3_r - qp[VAL_W+1:0];
      if (v4_r) acc_r <= mod_add(acc_base, red_twice(r4_r));
      done_r <= v4_r && l4_r;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= ORDER_W'(1);
      n_r         <= '0;
      o_r         <= '0;
      j_r         <= '0;
      hi_r        <= '0;
      xa_r        <= '0;
      first_r     <= 1'b0;
      xv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // flag a copy or parity read whose data is written back next cycle
      xv_r <= (state_r == S_COPY) || (state_r == S_PAR);
      if (cfg_we) order_r <= cfg_data;
      if (out_valid_r && out_ready && state_r != S_OUT_DATA) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && in_command == CMD_RUN) begin
            n_r     <= in_term_number - 1'b1;
            state_r <= S_TEST;
          end
        end
        S_TEST: begin
          if (n_r >= NUM_W'(k)) begin
            o_r     <= k;
            j_r     <= CW'(1);
            first_r <= 1'b1;
            state_r <= S_EXT_ISSUE;
          end else begin
            state_r <= S_OUT_RD;
          end
        end
        S_EXT_ISSUE: begin
          first_r <= 1'b0;
          j_r     <= j_r + 1'b1;
          if (j_r == k) state_r <= S_EXT_WAIT;
        end
        S_EXT_WAIT: begin
          if (done_r) begin
            first_r <= 1'b1;
            if (o_r == k2 - 1'b1) begin
              o_r     <= '0;
              j_r     <= '0;
              hi_r    <= '0;
              state_r <= S_SQ_ISSUE;
            end else begin
              o_r     <= o_r + 1'b1;
              j_r     <= CW'(1);
              state_r <= S_EXT_ISSUE;
            end
          end
        end
        S_SQ_ISSUE: begin
          first_r <= 1'b0;
          j_r     <= j_r + 1'b1;
          if (j_r == hi_r) state_r <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (done_r) begin
            if (o_r == k) begin
              o_r     <= '0;
              state_r <= S_COPY;
            end else begin
              o_r     <= o_r + 1'b1;
              j_r     <= lo_n;
              hi_r    <= hi_n;
              first_r <= 1'b1;
              state_r <= S_SQ_ISSUE;
            end
          end
        end
        S_COPY: begin
          xa_r <= o_r;
          o_r  <= o_r + 1'b1;
          if (o_r == k) state_r <= S_COPY_END;
        end
        S_COPY_END: begin
          o_r     <= '0;
          state_r <= S_PAR;
        end
        S_PAR: begin
          xa_r <= o_r;
          o_r  <= o_r + 1'b1;
          if (o_r == k - 1'b1) state_r <= S_PAR_END;
        end
        S_PAR_END: state_r <= S_HALVE;
        S_HALVE: begin
          n_r     <= n_r >> 1;
          state_r <= S_TEST;
        end
        S_OUT_RD: state_r <= S_OUT_DATA;
        S_OUT_DATA: begin
          if (!out_valid_r || out_ready) begin
            out_term_r  <= term_rd;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/lrn_chk.sv]
module lrn_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [lrn_pkg::CMD_W-1:0]   in_command,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lrn_pkg::VAL_W-1:0]   out_term
);
  import lrn_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_term))
    else $error("stalled result changed");

  // reset drops the result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a run blocks further items while it works
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_RUN |=> !in_ready)
    else $error("item accepted during run");

  // a load never creates a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != CMD_RUN && !out_valid |=> !out_valid)
    else $error("load item produced a result");

  // a new result appears only at the end of a run
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a run");

endmodule

bind linear_recurrence_nth_term_mod lrn_chk u_lrn_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .in_command(in_command),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_term(out_term)
);

[sim/tb.sv]
module tb;
  import lrn_pkg::*;

  localparam longint unsigned MOD_P = 64'd104857601;
  localparam int MAXO = MAX_ORDER_DEF;
  localparam int WATCHDOG_LIMIT = 500000;

  // predictor of the recurrence engine and queue of terms still owed
  class term_scoreboard;
    longint unsigned terms[0:2*MAXO-1];
    longint unsigned denom[0:MAXO];
    longint unsigned neg_denom[0:MAXO];
    longint unsigned half_prod[0:MAXO];
    int unsigned order_reg;
    bit [VAL_W-1:0] owed_terms[$];
    int errors;

    function new();
      for (int i = 0; i < 2*MAXO; i++) terms[i] = 0;
      for (int i = 0; i <= MAXO; i++) denom[i] = 0;
      denom[0] = 1;
      order_reg = 1;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void set_order(bit [ORDER_W-1:0] v);
      order_reg = v;
    endfunction

    // advance the stored state by one accepted item
    function void note_input(bit [CMD_W-1:0] cmd, bit [POS_W-1:0] pos,
                             bit [VAL_W-1:0] val, bit [NUM_W-1:0] num);
      longint unsigned v;
      longint unsigned acc;
      int kk;
      int w;
      int top;
      int lo;
      int hi;
      bit [NUM_W-1:0] idx;
      v = val % MOD_P;
      case (cmd_t'(cmd))
        CMD_LOAD_TERM: if (pos < MAXO) terms[pos] = v;
        CMD_LOAD_COEF: if (pos >= 1 && pos <= MAXO) denom[pos] = (MOD_P - v) % MOD_P;
        CMD_RUN: begin
          kk = (order_reg == 0) ? 1 : (order_reg > MAXO ? MAXO : order_reg);
          idx = num - 60'd1;
          while (idx >= kk) begin
            // extend terms to 2k
            for (int i = kk; i < 2*kk; i++) begin
              acc = 0;
              for (int j = 1; j <= kk; j++)
                acc = (acc + ((MOD_P - denom[j]) % MOD_P) * terms[i-j]) % MOD_P;
              terms[i] = acc;
            end
            // even part of Q(x)Q(-x)
            for (int i = 0; i <= kk; i++)
              neg_denom[i] = (i % 2 == 1) ? (MOD_P - denom[i]) % MOD_P : denom[i];
            for (int m = 0; m <= kk; m++) begin
              top = 2*m;
              lo = (top > kk) ? top - kk : 0;
              hi = (top < kk) ? top : kk;
              acc = 0;
              for (int j = lo; j <= hi; j++)
                acc = (acc + denom[j] * neg_denom[top-j]) % MOD_P;
              half_prod[m] = acc;
            end
            for (int i = 0; i <= kk; i++) denom[i] = half_prod[i];
            // keep terms of matching parity
            w = 0;
            for (int i = 0; i < 2*kk; i++) begin
              if ((i % 2) == idx[0]) begin
                terms[w] = terms[i];
                w++;
              end
            end
            idx = idx >> 1;
          end
          owed_terms.push_back(terms[idx][VAL_W-1:0]);
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [VAL_W-1:0] t);
      bit [VAL_W-1:0] want;
      if (owed_terms.size() == 0) begin
        report($sformatf("term %0d arrived with none owed", t));
      end else begin
        want = owed_terms.pop_front();
        if (t !== want) report($sformatf("term got %0d want %0d", t, want));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [ORDER_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = '0;
  logic [POS_W-1:0] in_position = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic [NUM_W-1:0] in_term_number = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [VAL_W-1:0] out_term;

  term_scoreboard sb = new();
  bit gaps_on = 1;
  bit stalls_on = 1;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int rand_items = 0;

  linear_recurrence_nth_term_mod dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_position(in_position), .in_value(in_value), .in_term_number(in_term_number),
    .out_valid(out_valid), .out_ready(out_ready), .out_term(out_term)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: check taken terms, stall in bursts, honor long holds
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_term);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else if (hold_done != hold_reqs) begin
      hold_done = hold_reqs;
      hold_left = 20000;
      out_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one item and hold it until taken
  task send_item(bit [CMD_W-1:0] cmd, bit [POS_W-1:0] pos,
                 bit [VAL_W-1:0] val, bit [NUM_W-1:0] num);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_position <= pos;
    in_value <= val;
    in_term_number <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, pos, val, num);
  endtask

  // drop valid and wait until every owed term is back
  task wait_drained();
    in_valid <= 0;
    while (sb.owed_terms.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task write_order(bit [ORDER_W-1:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_order(v);
  endtask

  function automatic bit [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return VAL_W'(MOD_P - 1);
      2: return VAL_W'($urandom_range(32'(MOD_P), 32'h7FFFFFF));
      default: return VAL_W'($urandom_range(0, 32'(MOD_P) - 1));
    endcase
  endfunction

  function automatic bit [NUM_W-1:0] rand_number(int max_bits);
    bit [63:0] r;
    int nb;
    r = {$urandom, $urandom};
    nb = $urandom_range(1, max_bits);
    if ($urandom_range(0, 24) == 0) return 0;
    return r[NUM_W-1:0] & ((60'd1 << nb) - 60'd1);
  endfunction

  // an ignored item: bad position or unknown command
  task send_noise();
    case ($urandom_range(0, 2))
      0: send_item(CMD_LOAD_TERM, POS_W'($urandom_range(MAXO, 2047)), rand_value(),
                   rand_number(60));
      1: send_item(CMD_LOAD_COEF, $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(MAXO + 1, 2047)),
                   rand_value(), rand_number(60));
      default: send_item(CMD_NONE, POS_W'($urandom_range(0, 2047)), VAL_W'($urandom),
                         rand_number(60));
    endcase
  endtask

  // reload all terms and coefficients, then ask for one term
  task run_sequence(int kk, bit [NUM_W-1:0] num, bit count_it);
    for (int i = 0; i < kk; i++) begin
      send_item(CMD_LOAD_TERM, POS_W'(i), rand_value(), rand_number(60));
      if (count_it && $urandom_range(0, 19) == 0) send_noise();
    end
    for (int i = 1; i <= kk; i++) begin
      send_item(CMD_LOAD_COEF, POS_W'(i), rand_value(), rand_number(60));
      if (count_it && $urandom_range(0, 19) == 0) send_noise();
    end
    // overwrite a few entries again at random
    if (count_it) begin
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 1))
          send_item(CMD_LOAD_TERM, POS_W'($urandom_range(0, kk - 1)), rand_value(), 0);
        else send_item(CMD_LOAD_COEF, POS_W'($urandom_range(1, kk)), rand_value(), 0);
      end
    end
    send_item(CMD_RUN, POS_W'($urandom), VAL_W'($urandom), num);
    if (count_it) rand_items += 2*kk + 1;
  endtask

  initial begin
    int kk;
    int nseq;
    int max_bits;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset order, extreme values, ignored items, term number zero
    send_item(CMD_LOAD_TERM, 0, VAL_W'(MOD_P - 1), 0);
    send_item(CMD_LOAD_COEF, 1, 27'h7FFFFFF, 0);
    send_item(CMD_LOAD_TERM, POS_W'(MAXO), 27'h5555555, 0);
    send_item(CMD_LOAD_TERM, 2047, 27'h2AAAAAA, 0);
    send_item(CMD_LOAD_COEF, 0, 27'h1234567, 0);
    send_item(CMD_LOAD_COEF, 2047, 27'h7654321, 0);
    send_item(CMD_NONE, 11'h7FF, 27'h7FFFFFF, 60'hFFFFFFFFFFFFFFF);
    send_item(CMD_RUN, 0, 0, 0);
    send_item(CMD_LOAD_TERM, 0, 0, 0);
    send_item(CMD_LOAD_COEF, 1, VAL_W'(MOD_P), 0);
    send_item(CMD_RUN, 11'h7FF, 27'h7FFFFFF, 60'hFFFFFFFFFFFFFFF);
    send_item(CMD_LOAD_TERM, 0, 27'h7FFFFFF, 0);
    send_item(CMD_LOAD_COEF, 1, 1, 0);
    send_item(CMD_RUN, 0, 0, 1);
    wait_drained();
    write_order(0);
    run_sequence(1, 60'd1000, 0);
    wait_drained();
    write_order(2);
    run_sequence(2, 60'd2, 0);
    wait_drained();
    // largest order: the wanted term lies below k, so only that term is read
    write_order(ORDER_W'(MAXO));
    kk = $urandom_range(0, MAXO - 1);
    send_item(CMD_LOAD_TERM, POS_W'(kk), rand_value(), 0);
    send_item(CMD_RUN, 0, 0, NUM_W'(kk + 1));
    wait_drained();
    write_order(11'h7FF);
    send_item(CMD_LOAD_TERM, POS_W'(MAXO - 1), rand_value(), 0);
    send_item(CMD_RUN, 0, 0, NUM_W'(MAXO));
    wait_drained();

    // random phases; the first one holds off the receiver for a long stretch
    hold_reqs++;
    while (rand_items < 700) begin
      if (rand_items >= 600) begin
        gaps_on = 0;
        stalls_on = 0;
      end
      case ($urandom_range(0, 19))
        0: kk = $urandom_range(13, 24);
        1, 2, 3, 4, 5: kk = $urandom_range(5, 12);
        default: kk = $urandom_range(1, 4);
      endcase
      nseq = $urandom_range(1, 4);
      // keep the held phase short so later runs queue behind the first term
      if (rand_items == 0) begin
        kk = $urandom_range(1, 4);
        nseq = 3;
      end
      max_bits = (kk > 12) ? 20 : 60;
      if (kk == 1 && $urandom_range(0, 3) == 0) write_order(0);
      else write_order(ORDER_W'(kk));
      repeat (nseq) run_sequence(kk, rand_number(max_bits), 1);
      wait_drained();
    end

    wait_drained();
    if (sb.errors == 0 && sb.owed_terms.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
rtl/lrn_pkg.sv
rtl/lrn_ram.sv
rtl/linear_recurrence_nth_term_mod.sv
rtl/lrn_chk.sv
sim/tb.sv
